[sv/mie_pkg.sv]
// ----------------------------------------------------------------------------
// mie_pkg
// shared types and opcode constants of the integer execute core
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned NUM_REGS   = 32;
  localparam int unsigned REG_AW     = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [REG_AW-1:0] LINK_REG = 5'd31;

  // major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2a;
  localparam logic [5:0] OP_SW      = 6'h2b;
  localparam logic [5:0] OP_SWR     = 6'h2e;
  localparam logic [5:0] OP_LL      = 6'h30;
  localparam logic [5:0] OP_LWC3    = 6'h33;
  localparam logic [5:0] OP_SC      = 6'h38;

  // special functions
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_BREAK   = 6'h0d;
  localparam logic [5:0] FN_SYNC    = 6'h0f;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  // regimm rt codes
  localparam logic [4:0] RT_BLTZ    = 5'h00;
  localparam logic [4:0] RT_BGEZ    = 5'h01;
  localparam logic [4:0] RT_BLTZAL  = 5'h10;
  localparam logic [4:0] RT_BGEZAL  = 5'h11;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;

  // class decided by the front end
  typedef enum logic [1:0] {
    CLS_SINGLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2,
    CLS_FAULT  = 2'd3
  } cls_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic        reg_write_enable;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic [31:0] mem_address;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  mem_write_size;
    logic [31:0] mem_write_data;
    logic [31:0] branch_target;
    logic        delay_slot;
    logic        branch_taken;
    logic        fault;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    cls_e     cls;
  } dec_item_t;

endpackage

[sv/mips_integer_execute_core.sv]
// ----------------------------------------------------------------------------
// mips_integer_execute_core
// MIPS I integer execute unit with register file and hi/lo
// ----------------------------------------------------------------------------
// Input channel: push / full with in_item_i (instruction, pc, load_data).
// Result channel: empty / pop with out_item_o; one result per item, in
// order. A two-entry queue decouples the classifier from the execute stage.
// Path: an accepted item waits in the queue and a plain instruction's result
// is then registered in the result register; mult and multu also pass the
// multiply unit, div and divu the radix-2 divider (32 steps, a sign fix-up
// and the done handoff). The single result register must be popped before
// the next item retires, so a new item is taken only once the last result is
// popped; a divide holds the execute stage until the divider is done.
// The execute stage holds one result register; while it is full and not
// popped, the queue fills and then full stays high.
// Reset makes the register file read zero, clears hi and lo and empties everything.
// ----------------------------------------------------------------------------
module mips_integer_execute_core #(
  parameter int unsigned QueueDepth = mie_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  mie_pkg::in_item_t   in_item_i,
  output logic                empty,
  input  logic                pop,
  output mie_pkg::out_item_t  out_item_o
);
  import mie_pkg::*;

  logic       q_valid, q_take;
  dec_item_t  q_item;

  mie_front #(.Depth(QueueDepth)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .item_i  (in_item_i),
    .valid_o (q_valid),
    .take_i  (q_take),
    .dec_o   (q_item)
  );

  mie_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .take_o   (q_take),
    .dec_i    (q_item),
    .empty_o  (empty),
    .pop_i    (pop),
    .result_o (out_item_o)
  );

endmodule

[sv/mie_front.sv]
// ----------------------------------------------------------------------------
// mie_front
// accepts items, classifies the encoding and queues them for the back end
// ----------------------------------------------------------------------------
module mie_front #(
  parameter int unsigned Depth = mie_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  mie_pkg::in_item_t   item_i,
  output logic                valid_o,
  input  logic                take_i,
  output mie_pkg::dec_item_t  dec_o
);
  import mie_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  dec_item_t         mem_q [Depth];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;
  dec_item_t         dec;
  logic [5:0]        op, fn;
  logic [4:0]        rt;
  logic              do_push, do_pop;

  assign op = item_i.instruction[31:26];
  assign fn = item_i.instruction[5:0];
  assign rt = item_i.instruction[20:16];

  always_comb begin
    dec.item = item_i;
    dec.cls  = CLS_SINGLE;
    unique case (op)
      OP_SPECIAL: begin
        case (fn) inside
          FN_MULT, FN_MULTU: dec.cls = CLS_MUL;
          FN_DIV, FN_DIVU:   dec.cls = CLS_DIV;
          FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
          FN_SYSCALL, FN_BREAK, FN_SYNC, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
          FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
          FN_SLT, FN_SLTU:   dec.cls = CLS_SINGLE;
          default:           dec.cls = CLS_FAULT;
        endcase
      end
      OP_REGIMM: begin
        case (rt) inside
          RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL: dec.cls = CLS_SINGLE;
          default:                                dec.cls = CLS_FAULT;
        endcase
      end
      OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
      OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH,
      OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH, OP_SWL, OP_SW,
      OP_SWR, OP_LL, OP_LWC3, OP_SC: dec.cls = CLS_SINGLE;
      default: dec.cls = CLS_FAULT;
    endcase
  end

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;
  assign dec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

[sv/mie_muldiv.sv]
// ----------------------------------------------------------------------------
// mie_muldiv
// multi-cycle unit: a 33x33 multiply or a radix-2 restoring divide
// ----------------------------------------------------------------------------
module mie_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_div_i,
  input  logic        signed_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] hi_o,
  output logic [31:0] lo_o
);
  import mie_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX
  } state_e;

  state_e       state_q;
  logic [5:0]   cnt_q;
  logic [31:0]  quo_q, rem_q, dvs_q;
  logic         nq_q, nr_q, zero_q, sgn_q;
  logic signed [32:0] ma_q, mb_q;
  logic [65:0]  prod;
  logic [33:0]  trial;
  logic [31:0]  abs_a, abs_b;

  assign prod  = $signed(ma_q) * $signed(mb_q);
  // shifted remainder can reach 33 bits, keep a separate borrow bit
  assign trial = {1'b0, rem_q, quo_q[31]} - {2'b00, dvs_q};
  assign abs_a = (signed_i && a_i[31]) ? (32'd0 - a_i) : a_i;
  assign abs_b = (signed_i && b_i[31]) ? (32'd0 - b_i) : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_o  <= 1'b0;
      cnt_q   <= '0;
      hi_o    <= '0;
      lo_o    <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      nq_q    <= 1'b0;
      nr_q    <= 1'b0;
      zero_q  <= 1'b0;
      sgn_q   <= 1'b0;
      ma_q    <= '0;
      mb_q    <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            if (is_div_i) begin
              quo_q   <= abs_a;
              rem_q   <= '0;
              dvs_q   <= abs_b;
              nq_q    <= signed_i && (a_i[31] != b_i[31]);
              nr_q    <= signed_i && a_i[31];
              zero_q  <= (b_i == '0);
              sgn_q   <= signed_i;
              cnt_q   <= '0;
              state_q <= ST_DIV;
            end else begin
              ma_q    <= {signed_i && a_i[31], a_i};
              mb_q    <= {signed_i && b_i[31], b_i};
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          hi_o    <= prod[63:32];
          lo_o    <= prod[31:0];
          done_o  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_DIV: begin
          // one quotient bit per cycle
          if (!trial[33]) begin
            rem_q <= trial[31:0];
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= {rem_q[30:0], quo_q[31]};
            quo_q <= {quo_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd31) begin
            state_q <= ST_FIX;
          end
        end
        ST_FIX: begin
          if (zero_q) begin
            hi_o <= sgn_q ? 32'h7fffffff : 32'hffffffff;
            lo_o <= sgn_q ? 32'h7fffffff : 32'hffffffff;
          end else begin
            hi_o <= nr_q ? (32'd0 - rem_q) : rem_q;
            lo_o <= nq_q ? (32'd0 - quo_q) : quo_q;
          end
          done_o  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/mie_back.sv]
// ----------------------------------------------------------------------------
// mie_back
// executes queued items against the register file and hi/lo
// ----------------------------------------------------------------------------
module mie_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                take_o,
  input  mie_pkg::dec_item_t  dec_i,
  output logic                empty_o,
  input  logic                pop_i,
  output mie_pkg::out_item_t  result_o
);
  import mie_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e       state_q;
  logic [31:0]  rf_q [NUM_REGS];
  logic [NUM_REGS-1:0] rfv_q;
  logic [31:0]  hi_q, lo_q;
  out_item_t    res_q;
  logic         full_q;

  logic [31:0]  ins, pc, ld, vs, vt, simm, addr, btgt, wv, ma, mdata, tgt, nhi, nlo;
  logic [5:0]   op, fn;
  logic [4:0]   rs, rt, rd, sa, wi;
  logic [4:0]   sh;
  logic         we, mr, mw, bd, bt, hl;
  logic [1:0]   msz;
  out_item_t    res;

  logic         md_start, md_done;
  logic [31:0]  md_hi, md_lo;

  assign ins  = dec_i.item.instruction;
  assign pc   = dec_i.item.pc;
  assign ld   = dec_i.item.load_data;
  assign op   = ins[31:26];
  assign rs   = ins[25:21];
  assign rt   = ins[20:16];
  assign rd   = ins[15:11];
  assign sa   = ins[10:6];
  assign fn   = ins[5:0];
  assign vs   = rfv_q[rs] ? rf_q[rs] : '0;
  assign vt   = rfv_q[rt] ? rf_q[rt] : '0;
  assign simm = {{16{ins[15]}}, ins[15:0]};
  assign addr = vs + simm;
  assign btgt = pc + 32'd4 + {simm[29:0], 2'b00};

  always_comb begin
    we = 1'b0; mr = 1'b0; mw = 1'b0; bd = 1'b0; bt = 1'b0; hl = 1'b0;
    wi = '0; wv = '0; ma = '0; msz = '0; mdata = '0; tgt = '0;
    nhi = hi_q; nlo = lo_q; sh = '0;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_ADD, FN_ADDU: begin we = 1'b1; wi = rd; wv = vs + vt; end
          FN_SUB, FN_SUBU: begin we = 1'b1; wi = rd; wv = vs - vt; end
          FN_AND:  begin we = 1'b1; wi = rd; wv = vs & vt; end
          FN_OR:   begin we = 1'b1; wi = rd; wv = vs | vt; end
          FN_XOR:  begin we = 1'b1; wi = rd; wv = vs ^ vt; end
          FN_NOR:  begin we = 1'b1; wi = rd; wv = ~(vs | vt); end
          FN_SLL:  begin we = 1'b1; wi = rd; wv = vt << sa; end
          FN_SLLV: begin we = 1'b1; wi = rd; wv = vt << vs[4:0]; end
          FN_SRL:  begin we = 1'b1; wi = rd; wv = vt >> sa; end
          FN_SRLV: begin we = 1'b1; wi = rd; wv = vt >> vs[4:0]; end
          FN_SRA:  begin we = 1'b1; wi = rd; wv = 32'($signed(vt) >>> sa); end
          FN_SRAV: begin we = 1'b1; wi = rd; wv = 32'($signed(vt) >>> vs[4:0]); end
          FN_SLT:  begin we = 1'b1; wi = rd; wv = {31'd0, $signed(vs) < $signed(vt)}; end
          FN_SLTU: begin we = 1'b1; wi = rd; wv = {31'd0, vs < vt}; end
          FN_MFHI: begin we = 1'b1; wi = rd; wv = hi_q; end
          FN_MFLO: begin we = 1'b1; wi = rd; wv = lo_q; end
          FN_MTHI: begin hl = 1'b1; nhi = vs; end
          FN_MTLO: begin hl = 1'b1; nlo = vs; end
          FN_JALR: begin
            tgt = vs; bd = 1'b1; bt = 1'b1; we = 1'b1; wi = rd; wv = pc + 32'd8;
          end
          FN_JR:   begin tgt = vs; bd = 1'b1; bt = 1'b1; end
          default: ;
        endcase
      end
      OP_ADDI, OP_ADDIU: begin we = 1'b1; wi = rt; wv = vs + simm; end
      OP_ANDI: begin we = 1'b1; wi = rt; wv = vs & {16'd0, ins[15:0]}; end
      OP_ORI:  begin we = 1'b1; wi = rt; wv = vs | {16'd0, ins[15:0]}; end
      OP_XORI: begin we = 1'b1; wi = rt; wv = vs ^ {16'd0, ins[15:0]}; end
      OP_LUI:  begin we = 1'b1; wi = rt; wv = {ins[15:0], 16'd0}; end
      OP_SLTI: begin we = 1'b1; wi = rt; wv = {31'd0, $signed(vs) < $signed(simm)}; end
      OP_SLTIU: begin we = 1'b1; wi = rt; wv = {31'd0, vs < simm}; end
      OP_BEQ:  begin tgt = btgt; bd = 1'b1; bt = (vs == vt); end
      OP_BNE:  begin tgt = btgt; bd = 1'b1; bt = (vs != vt); end
      OP_BLEZ: begin tgt = btgt; bd = 1'b1; bt = (vs == '0) || vs[31]; end
      OP_BGTZ: begin tgt = btgt; bd = 1'b1; bt = (vs != '0) && !vs[31]; end
      OP_REGIMM: begin
        tgt = btgt; bd = 1'b1; bt = rt[0] ? !vs[31] : vs[31];
        if (rt[4]) begin
          we = 1'b1; wi = LINK_REG; wv = pc + 32'd8;
        end
      end
      OP_J, OP_JAL: begin
        // upper bits come from pc + 4
        tgt = {pc[31:28] + {3'd0, &pc[27:2]}, ins[25:0], 2'b00};
        bd = 1'b1; bt = 1'b1;
        if (op == OP_JAL) begin
          we = 1'b1; wi = LINK_REG; wv = pc + 32'd8;
        end
      end
      OP_LB:  begin ma = addr; mr = 1'b1; we = 1'b1; wi = rt; wv = {{24{ld[7]}}, ld[7:0]}; end
      OP_LBU: begin ma = addr; mr = 1'b1; we = 1'b1; wi = rt; wv = {24'd0, ld[7:0]}; end
      OP_LH:  begin ma = addr; mr = 1'b1; we = 1'b1; wi = rt; wv = {{16{ld[15]}}, ld[15:0]}; end
      OP_LHU: begin ma = addr; mr = 1'b1; we = 1'b1; wi = rt; wv = {16'd0, ld[15:0]}; end
      OP_LW:  begin ma = addr; mr = 1'b1; we = 1'b1; wi = rt; wv = ld; end
      OP_LWL: begin
        ma = addr; mr = 1'b1; we = 1'b1; wi = rt;
        sh = {addr[1:0], 3'b000};
        wv = (ld << sh) | (vt & ~(32'hffffffff << sh));
      end
      OP_LWR: begin
        ma = addr; mr = 1'b1; we = 1'b1; wi = rt;
        sh = {~addr[1:0], 3'b000};
        wv = (ld >> sh) | (vt & ~(32'hffffffff >> sh));
      end
      OP_SB: begin ma = addr; mw = 1'b1; msz = SIZE_BYTE; mdata = {24'd0, vt[7:0]}; end
      OP_SH: begin ma = addr; mw = 1'b1; msz = SIZE_HALF; mdata = {16'd0, vt[15:0]}; end
      OP_SW: begin ma = addr; mw = 1'b1; msz = SIZE_WORD; mdata = vt; end
      OP_SWL: begin
        ma = addr; mr = 1'b1; mw = 1'b1; msz = SIZE_WORD;
        sh = {addr[1:0], 3'b000};
        mdata = (vt >> sh) | (ld & ~(32'hffffffff >> sh));
      end
      OP_SWR: begin
        ma = addr; mr = 1'b1; mw = 1'b1; msz = SIZE_WORD;
        sh = {~addr[1:0], 3'b000};
        mdata = (vt << sh) | (ld & ~(32'hffffffff << sh));
      end
      default: ;
    endcase

    res = '0;
    if (dec_i.cls == CLS_FAULT) begin
      res.fault = 1'b1;
    end else if (dec_i.cls == CLS_SINGLE) begin
      if (we && wi != '0) begin
        res.reg_write_enable = 1'b1;
        res.reg_write_index  = wi;
        res.reg_write_value  = wv;
      end
      res.mem_address    = ma;
      res.mem_read       = mr;
      res.mem_write      = mw;
      res.mem_write_size = msz;
      res.mem_write_data = mdata;
      res.branch_target  = tgt;
      res.delay_slot     = bd;
      res.branch_taken   = bt;
    end
  end

  // single and fault items retire straight from idle, mul/div go through the unit
  assign md_start = (state_q == ST_IDLE) && valid_i && !full_q &&
                    (dec_i.cls == CLS_MUL || dec_i.cls == CLS_DIV);
  assign take_o   = ((state_q == ST_IDLE) && valid_i && !full_q &&
                     (dec_i.cls == CLS_SINGLE || dec_i.cls == CLS_FAULT)) ||
                    ((state_q == ST_WAIT) && md_done);
  assign empty_o  = !full_q;
  assign result_o = res_q;

  mie_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .is_div_i (dec_i.cls == CLS_DIV),
    .signed_i (!fn[0]),
    .a_i      (vs),
    .b_i      (vt),
    .done_o   (md_done),
    .hi_o     (md_hi),
    .lo_o     (md_lo)
  );

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      full_q  <= 1'b0;
      rfv_q   <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
    end else begin
      if (pop_i && full_q) begin
        full_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (md_start) begin
            state_q <= ST_WAIT;
          end else if (take_o) begin
            full_q <= 1'b1;
            if (dec_i.cls == CLS_SINGLE && hl) begin
              hi_q <= nhi;
              lo_q <= nlo;
            end
            if (dec_i.cls == CLS_SINGLE && we && wi != '0) begin
              rfv_q[wi] <= 1'b1;
            end
          end
        end
        ST_WAIT: begin
          if (md_done) begin
            hi_q    <= md_hi;
            lo_q    <= md_lo;
            full_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && take_o && dec_i.cls == CLS_SINGLE && we && wi != '0) begin
      rf_q[wi] <= wv;
    end
  end

endmodule

[sv/mie_checker.sv]
// ----------------------------------------------------------------------------
// mie_checker
// port-level checks of the integer execute core
// ----------------------------------------------------------------------------
module mie_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input mie_pkg::out_item_t out_item_o
);
  import mie_pkg::*;

  // handshake lines are always driven
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({push, full, empty, pop}))
    else $error("unknown handshake");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed while waiting");

  // a fault result carries no register write, memory write or branch
  a_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.fault) |-> (!out_item_o.reg_write_enable &&
      !out_item_o.mem_write && !out_item_o.delay_slot))
    else $error("fault with side effects");

  // register zero is never written
  a_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.reg_write_enable) |-> (out_item_o.reg_write_index != 5'd0))
    else $error("write to register zero");

  // taken only on branches
  a_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.branch_taken) |-> out_item_o.delay_slot)
    else $error("taken without branch");

endmodule

bind mips_integer_execute_core mie_checker u_mie_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

[sim/tb_mips_integer_execute_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_integer_execute_core
// self-checking bench for the integer execute core: a directed table of
// instructions followed by random, mostly legal programs, every result checked
// against an in-bench model of the register file and hi/lo
// ----------------------------------------------------------------------------
module tb_mips_integer_execute_core;
  import mie_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumRandom = 1130;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_item_t in_item_i = '0;
  out_item_t out_item_o;

  mips_integer_execute_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

  always #10 clk_i = ~clk_i;

  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q;
  out_item_t   pending_results [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // executes one instruction on the bench copy of the state
  function automatic out_item_t execute_instr(in_item_t it);
    out_item_t   r;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa, wi;
    logic [31:0] vs, vt, addr, bta, wv, nhi, nlo, ld, ins, pc, q, rm, m1, m2;
    logic [63:0] p;
    logic [4:0]  sh;
    logic        we, hl;
    ins = it.instruction; pc = it.pc; ld = it.load_data;
    op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
    sa = ins[10:6]; fn = ins[5:0];
    vs = gpr[rs]; vt = gpr[rt];
    addr = vs + sx16(ins[15:0]);
    bta = pc + 32'd4 + (sx16(ins[15:0]) << 2);
    r = '0; we = 1'b0; hl = 1'b0; wi = '0; wv = '0; nhi = '0; nlo = '0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SYNC, FN_BREAK, FN_SYSCALL: ;
          FN_ADD, FN_ADDU: begin we = 1; wi = rd; wv = vs + vt; end
          FN_SUB, FN_SUBU: begin we = 1; wi = rd; wv = vs - vt; end
          FN_AND: begin we = 1; wi = rd; wv = vs & vt; end
          FN_OR:  begin we = 1; wi = rd; wv = vs | vt; end
          FN_XOR: begin we = 1; wi = rd; wv = vs ^ vt; end
          FN_NOR: begin we = 1; wi = rd; wv = ~(vs | vt); end
          FN_SLL:  begin we = 1; wi = rd; wv = vt << sa; end
          FN_SLLV: begin we = 1; wi = rd; wv = vt << vs[4:0]; end
          FN_SRL:  begin we = 1; wi = rd; wv = vt >> sa; end
          FN_SRLV: begin we = 1; wi = rd; wv = vt >> vs[4:0]; end
          FN_SRA:  begin we = 1; wi = rd; wv = $signed(vt) >>> sa; end
          FN_SRAV: begin we = 1; wi = rd; wv = $signed(vt) >>> vs[4:0]; end
          FN_SLT:  begin we = 1; wi = rd; wv = {31'd0, $signed(vs) < $signed(vt)}; end
          FN_SLTU: begin we = 1; wi = rd; wv = {31'd0, vs < vt}; end
          FN_DIV: begin
            hl = 1;
            if (vt == 0) begin
              nhi = 32'h7fffffff; nlo = 32'h7fffffff;
            end else begin
              m1 = vs[31] ? -vs : vs; m2 = vt[31] ? -vt : vt;
              q = m1 / m2; rm = m1 % m2;
              nlo = (vs[31] != vt[31]) ? -q : q;
              nhi = vs[31] ? -rm : rm;
            end
          end
          FN_DIVU: begin
            hl = 1;
            if (vt == 0) begin
              nhi = '1; nlo = '1;
            end else begin
              nhi = vs % vt; nlo = vs / vt;
            end
          end
          FN_MFHI: begin we = 1; wi = rd; wv = hi_q; end
          FN_MFLO: begin we = 1; wi = rd; wv = lo_q; end
          FN_MTHI: begin hl = 1; nhi = vs; nlo = lo_q; end
          FN_MTLO: begin hl = 1; nhi = hi_q; nlo = vs; end
          FN_MULT: begin
            hl = 1; p = $signed({{32{vs[31]}}, vs}) * $signed({{32{vt[31]}}, vt});
            {nhi, nlo} = p;
          end
          FN_MULTU: begin hl = 1; p = {32'd0, vs} * {32'd0, vt}; {nhi, nlo} = p; end
          FN_JALR: begin
            r.branch_target = vs; r.delay_slot = 1; r.branch_taken = 1;
            we = 1; wi = rd; wv = pc + 32'd8;
          end
          FN_JR: begin r.branch_target = vs; r.delay_slot = 1; r.branch_taken = 1; end
          default: r.fault = 1;
        endcase
      end
      OP_ADDI, OP_ADDIU: begin we = 1; wi = rt; wv = vs + sx16(ins[15:0]); end
      OP_ANDI: begin we = 1; wi = rt; wv = vs & {16'd0, ins[15:0]}; end
      OP_ORI:  begin we = 1; wi = rt; wv = vs | {16'd0, ins[15:0]}; end
      OP_XORI: begin we = 1; wi = rt; wv = vs ^ {16'd0, ins[15:0]}; end
      OP_LUI:  begin we = 1; wi = rt; wv = {ins[15:0], 16'd0}; end
      OP_SLTI: begin we = 1; wi = rt; wv = {31'd0, $signed(vs) < $signed(sx16(ins[15:0]))}; end
      OP_SLTIU: begin we = 1; wi = rt; wv = {31'd0, vs < sx16(ins[15:0])}; end
      OP_BEQ:  begin r.branch_target = bta; r.delay_slot = 1; r.branch_taken = vs == vt; end
      OP_BNE:  begin r.branch_target = bta; r.delay_slot = 1; r.branch_taken = vs != vt; end
      OP_BLEZ: begin r.branch_target = bta; r.delay_slot = 1; r.branch_taken = vs == 0 || vs[31]; end
      OP_BGTZ: begin r.branch_target = bta; r.delay_slot = 1; r.branch_taken = vs != 0 && !vs[31]; end
      OP_REGIMM: begin
        r.branch_target = bta; r.delay_slot = 1;
        case (rt)
          RT_BGEZ:   r.branch_taken = !vs[31];
          RT_BLTZ:   r.branch_taken = vs[31];
          RT_BGEZAL: begin r.branch_taken = !vs[31]; we = 1; wi = LINK_REG; wv = pc + 32'd8; end
          RT_BLTZAL: begin r.branch_taken = vs[31]; we = 1; wi = LINK_REG; wv = pc + 32'd8; end
          default: r.fault = 1;
        endcase
      end
      OP_J, OP_JAL: begin
        r.branch_target = ((pc + 32'd4) & 32'hf0000000) | {4'd0, ins[25:0], 2'b00};
        r.delay_slot = 1; r.branch_taken = 1;
        if (op == OP_JAL) begin we = 1; wi = LINK_REG; wv = pc + 32'd8; end
      end
      OP_LB:  begin r.mem_address = addr; r.mem_read = 1; we = 1; wi = rt; wv = {{24{ld[7]}}, ld[7:0]}; end
      OP_LBU: begin r.mem_address = addr; r.mem_read = 1; we = 1; wi = rt; wv = {24'd0, ld[7:0]}; end
      OP_LH:  begin r.mem_address = addr; r.mem_read = 1; we = 1; wi = rt; wv = sx16(ld[15:0]); end
      OP_LHU: begin r.mem_address = addr; r.mem_read = 1; we = 1; wi = rt; wv = {16'd0, ld[15:0]}; end
      OP_LW:  begin r.mem_address = addr; r.mem_read = 1; we = 1; wi = rt; wv = ld; end
      OP_LWL: begin
        r.mem_address = addr; r.mem_read = 1; we = 1; wi = rt; sh = {addr[1:0], 3'b000};
        wv = (ld << sh) | (vt & ~(32'hffffffff << sh));
      end
      OP_LWR: begin
        r.mem_address = addr; r.mem_read = 1; we = 1; wi = rt; sh = {~addr[1:0], 3'b000};
        wv = (ld >> sh) | (vt & ~(32'hffffffff >> sh));
      end
      OP_SB: begin r.mem_address = addr; r.mem_write = 1; r.mem_write_size = SIZE_BYTE; r.mem_write_data = {24'd0, vt[7:0]}; end
      OP_SH: begin r.mem_address = addr; r.mem_write = 1; r.mem_write_size = SIZE_HALF; r.mem_write_data = {16'd0, vt[15:0]}; end
      OP_SW: begin r.mem_address = addr; r.mem_write = 1; r.mem_write_size = SIZE_WORD; r.mem_write_data = vt; end
      OP_SWL: begin
        r.mem_address = addr; r.mem_read = 1; r.mem_write = 1; r.mem_write_size = SIZE_WORD;
        sh = {addr[1:0], 3'b000};
        r.mem_write_data = (vt >> sh) | (ld & ~(32'hffffffff >> sh));
      end
      OP_SWR: begin
        r.mem_address = addr; r.mem_read = 1; r.mem_write = 1; r.mem_write_size = SIZE_WORD;
        sh = {~addr[1:0], 3'b000};
        r.mem_write_data = (vt << sh) | (ld & ~(32'hffffffff << sh));
      end
      OP_LL, OP_LWC3, OP_SC: ;
      default: r.fault = 1;
    endcase
    if (r.fault) return '{fault: 1'b1, default: '0};
    if (hl) begin
      hi_q = nhi; lo_q = nlo;
    end
    if (we && wi != 0) begin
      gpr[wi] = wv;
      r.reg_write_enable = 1; r.reg_write_index = wi; r.reg_write_value = wv;
    end
    return r;
  endfunction

  // result side: pops at random and checks in order
  always @(posedge clk_i) begin
    out_item_t exp_r;
    cycles <= cycles + 1;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item_o !== exp_r) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_item_o);
          if (out_item_o.reg_write_value !== exp_r.reg_write_value)
            $display("%0t:   reg value expected %h actual %h", $time,
                     exp_r.reg_write_value, out_item_o.reg_write_value);
          errors++;
        end
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("** mips_integer_execute_core: FAILED **");
      $finish;
    end
  end

  // hands one item over; the prediction is made when it is accepted
  // push stays high after the accept until the caller idles or drops it
  task automatic push_item(logic [31:0] ins, logic [31:0] pc, logic [31:0] ld);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= '{instruction: ins, pc: pc, load_data: ld};
    do @(posedge clk_i); while (full);
    pending_results.push_back(execute_instr('{instruction: ins, pc: pc, load_data: ld}));
  endtask

  function automatic logic [31:0] rtype(logic [4:0] rs, rt, rd, sa, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h80000000;
      3: return 32'h7fffffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly legal instructions over a small register set so values chain
  function automatic logic [31:0] rand_instr();
    logic [5:0] ops [] = '{OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
      OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB,
      OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR,
      OP_LL, OP_LWC3, OP_SC};
    logic [5:0] fns [] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
      FN_JALR, FN_SYSCALL, FN_BREAK, FN_SYNC, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
      FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND,
      FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    logic [4:0] regs [] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd31};
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(19) == 0) return w;
    w[25:21] = regs[$urandom_range(regs.size() - 1)];
    w[20:16] = regs[$urandom_range(regs.size() - 1)];
    if ($urandom_range(1)) begin
      w[31:26] = OP_SPECIAL;
      w[15:11] = regs[$urandom_range(regs.size() - 1)];
      w[5:0] = fns[$urandom_range(fns.size() - 1)];
      // divides are slow, keep them rarer
      if ((w[5:0] == FN_DIV || w[5:0] == FN_DIVU) && $urandom_range(2) != 0) w[5:0] = FN_ADDU;
    end else begin
      w[31:26] = ops[$urandom_range(ops.size() - 1)];
      if (w[31:26] == OP_REGIMM && $urandom_range(5) != 0)
        w[20:16] = $urandom_range(1) ? ($urandom_range(1) ? RT_BGEZAL : RT_BLTZAL)
                                     : ($urandom_range(1) ? RT_BGEZ : RT_BLTZ);
    end
    return w;
  endfunction

  typedef struct {
    logic [31:0] ins;
    logic [31:0] ld;
    logic        known;
    out_item_t   res;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    out_item_t nil;
    nil = '0;
    // after reset every register reads zero
    rows.push_back('{rtype(0, 0, 5'd1, 0, FN_ADDU), 32'h0, 1'b1, '{reg_write_enable: 1,
      reg_write_index: 5'd1, default: '0}});
    rows.push_back('{32'hffffffff, 32'h0, 1'b1, '{fault: 1, default: '0}});
    rows.push_back('{{6'h11, 26'h0}, 32'h0, 1'b1, '{fault: 1, default: '0}});
    rows.push_back('{rtype(0, 0, 0, 0, 6'h01), 32'h0, 1'b1, '{fault: 1, default: '0}});
    rows.push_back('{itype(OP_REGIMM, 0, 5'h02, 0), 32'h0, 1'b1, '{fault: 1, default: '0}});
    rows.push_back('{rtype(0, 0, 0, 0, FN_SYSCALL), 32'h0, 1'b1, nil});
    rows.push_back('{itype(OP_SC, 5'd1, 5'd2, 16'hffff), 32'h0, 1'b1, nil});
    // write to register zero is dropped
    rows.push_back('{itype(OP_LUI, 0, 0, 16'hffff), 32'h0, 1'b1, nil});
    rows.push_back('{itype(OP_LUI, 0, 5'd1, 16'h8000), 32'h0, 1'b1, '{reg_write_enable: 1,
      reg_write_index: 5'd1, reg_write_value: 32'h80000000, default: '0}});
    rows.push_back('{itype(OP_ADDIU, 0, 5'd2, 16'hffff), 32'h0, 1'b0, nil});
    rows.push_back('{itype(OP_ADDI, 5'd1, 5'd3, 16'hffff), 32'h0, 1'b0, nil});
    rows.push_back('{rtype(5'd1, 5'd2, 0, 0, FN_MULT), 32'h0, 1'b0, nil});
    rows.push_back('{rtype(0, 0, 5'd4, 0, FN_MFHI), 32'h0, 1'b0, nil});
    rows.push_back('{rtype(5'd1, 5'd2, 0, 0, FN_DIV), 32'h0, 1'b0, nil});
    rows.push_back('{rtype(0, 0, 5'd4, 0, FN_MFLO), 32'h0, 1'b0, nil});
    rows.push_back('{rtype(5'd1, 0, 0, 0, FN_DIV), 32'h0, 1'b0, nil});
    rows.push_back('{rtype(0, 0, 5'd5, 0, FN_MFHI), 32'h0, 1'b0, nil});
    rows.push_back('{rtype(5'd1, 0, 0, 0, FN_DIVU), 32'h0, 1'b0, nil});
    rows.push_back('{rtype(0, 0, 5'd5, 0, FN_MFLO), 32'h0, 1'b0, nil});
    rows.push_back('{itype(OP_REGIMM, 5'd1, RT_BGEZAL, 16'h8000), 32'h0, 1'b0, nil});
    rows.push_back('{rtype(5'd31, 0, 5'd31, 0, FN_JALR), 32'h0, 1'b0, nil});
    rows.push_back('{itype(OP_LB, 5'd2, 5'd6, 16'h7fff), 32'hffffff80, 1'b0, nil});
    rows.push_back('{itype(OP_LWL, 5'd3, 5'd6, 16'h0002), 32'h12345678, 1'b0, nil});
    rows.push_back('{itype(OP_SWR, 5'd3, 5'd2, 16'h0001), 32'hcafef00d, 1'b0, nil});
    rows.push_back('{{OP_JAL, 26'h3ffffff}, 32'h0, 1'b0, nil});

    for (int i = 0; i < 32; i++) gpr[i] = '0;
    hi_q = '0; lo_q = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      logic [31:0] pcv;
      out_item_t   want;
      pcv = (i == rows.size() - 1) ? 32'hfffffffc : 32'h00400000 + 4 * i;
      push_item(rows[i].ins, pcv, rows[i].ld);
      want = pending_results[$];
      if (rows[i].known && want !== rows[i].res) begin
        $display("%0t: table row %0d expected %h actual %h", $time, i, rows[i].res, want);
        errors++;
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 26 : 0;
      for (int n = 0; n < NumRandom / 3; n++) begin
        // seed registers with edge values now and then
        if ($urandom_range(6) == 0)
          push_item(itype(OP_LW, 0, 5'($urandom_range(1, 3)), 16'($urandom)), $urandom,
                    rand_word());
        else
          push_item(rand_instr(), $urandom, rand_word());
        if (n == 100) begin
          push <= 1'b0;
          wait (pending_results.size() == 0);
        end
      end
    end

    push <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("** mips_integer_execute_core: PASSED **");
    end else begin
      $display("** mips_integer_execute_core: FAILED **");
    end
    $finish;
  end

endmodule
